// File: rtl/core/skht_pkg.sv
// Shared types, sizes and helper functions for the sorted key/handle table.
// Used by the controller, the datapath, the top level and the port checker.
`default_nettype none

package skht_pkg;

    // Table geometry.
    localparam int CAPACITY    = 64;
    localparam int HANDLE_BITS = 16;

    // Field widths fixed by the port list.
    localparam int KEY_W  = 32;
    localparam int HOUT_W = 16;
    localparam int POS_W  = 6;
    localparam int RIDX_W = 6;
    localparam int ECNT_W = 7;

    // Widths that follow from the table size.
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int HCOPY_W = (HANDLE_BITS < HOUT_W) ? HANDLE_BITS : HOUT_W;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [HANDLE_BITS-1:0]  hnd_t;
    typedef logic [HOUT_W-1:0]       hout_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [CMP_W-1:0]        cmp_t;
    typedef logic [POS_W-1:0]        pos_t;
    typedef logic [RIDX_W-1:0]       ridx_t;
    typedef logic [ECNT_W-1:0]       ecnt_t;

    typedef struct packed {
        key_t key;
        hnd_t hnd;
    } entry_t;

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_FIND   = 3'd3,
        ACT_READ   = 3'd4,
        ACT_CLEAR  = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        RS_OK      = 2'd0,
        RS_FULL    = 2'd1,
        RS_BAD_POS = 2'd2
    } result_status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_CHECK,
        CS_WALK,
        CS_FINISH
    } ctrl_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;    // capture the request
        logic start;   // issue the first table read
        logic step;    // process one table entry
        logic finish;  // commit count and load the result register
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic no_walk;    // request needs no pass over the table
        logic step_last;  // the entry being processed ends the pass
        logic out_free;   // result register can take a new result
    } dp_status_t;

    function automatic hnd_t hnd_from_port(input hout_t h);
        hnd_t r;
        r = '0;
        for (int i = 0; i < HCOPY_W; i++) begin
            r[i] = h[i];
        end
        return r;
    endfunction

    function automatic hout_t hnd_to_port(input hnd_t h);
        hout_t r;
        r = '0;
        for (int i = 0; i < HCOPY_W; i++) begin
            r[i] = h[i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/skht_ctrl.sv
// Request sequencer of the sorted key/handle table.
// Depends on skht_pkg for the state, command and status types.
`default_nettype none

module skht_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire skht_pkg::dp_status_t   stat,
    output skht_pkg::ctrl_cmd_t         cmd
);

    skht_pkg::ctrl_state_t state_reg;
    skht_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= skht_pkg::CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = (state_reg == skht_pkg::CS_IDLE);
        unique case (state_reg)
            skht_pkg::CS_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = skht_pkg::CS_CHECK;
                end
            end
            skht_pkg::CS_CHECK: begin
                if (stat.no_walk) begin
                    state_next = skht_pkg::CS_FINISH;
                end else begin
                    cmd.start  = 1'b1;
                    state_next = skht_pkg::CS_WALK;
                end
            end
            skht_pkg::CS_WALK: begin
                cmd.step = 1'b1;
                if (stat.step_last) begin
                    state_next = skht_pkg::CS_FINISH;
                end
            end
            skht_pkg::CS_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = skht_pkg::CS_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/skht_dpath.sv
// Datapath of the sorted key/handle table: request registers, entry memory,
// walk pointers, the shift carry and the result register. Depends on skht_pkg.
`default_nettype none

module skht_dpath (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire skht_pkg::ctrl_cmd_t      cmd,
    output skht_pkg::dp_status_t          stat,
    input  wire logic [2:0]               s_action,
    input  wire logic signed [31:0]       s_key,
    input  wire logic [15:0]              s_handle,
    input  wire logic [5:0]               s_position,
    input  wire logic                     m_ready,
    output logic                          m_valid,
    output logic [5:0]                    m_result_index,
    output logic                          m_found,
    output logic signed [31:0]            m_key_out,
    output logic [15:0]                   m_handle_out,
    output logic [6:0]                    m_entry_count,
    output logic [1:0]                    m_status
);

    skht_pkg::entry_t entry_mem [skht_pkg::CAPACITY];

    // Request and walk registers.
    skht_pkg::action_t  act_reg,    act_next;
    skht_pkg::key_t     key_reg,    key_next;
    skht_pkg::hnd_t     hnd_reg,    hnd_next;
    skht_pkg::pos_t     pos_reg,    pos_next;
    skht_pkg::cnt_t     cnt_reg,    cnt_next;
    skht_pkg::idx_t     rd_ptr_reg, rd_ptr_next;
    skht_pkg::idx_t     proc_reg,   proc_next;
    logic               shift_reg,  shift_next;
    skht_pkg::entry_t   carry_reg,  carry_next;
    skht_pkg::entry_t   rdata_reg;
    skht_pkg::ridx_t    ridx_reg,   ridx_next;
    logic               found_reg,  found_next;
    skht_pkg::key_t     kout_reg,   kout_next;
    skht_pkg::hnd_t     hout_reg,   hout_next;

    // Result register.
    logic               m_valid_reg, m_valid_next;
    skht_pkg::ridx_t    m_ridx_reg;
    logic               m_found_reg;
    skht_pkg::key_t     m_key_reg;
    skht_pkg::hout_t    m_hnd_reg;
    skht_pkg::ecnt_t    m_cnt_reg;
    skht_pkg::result_status_t m_stat_reg;

    skht_pkg::result_status_t err;
    skht_pkg::cmp_t     pos_w, cnt_w;
    logic               full, rem_tail;
    skht_pkg::idx_t     pos_idx, start_addr, rd_addr;
    skht_pkg::entry_t   new_entry, wdata;
    skht_pkg::idx_t     waddr;
    logic               step_we, at_end, at_last, step_last;
    logic               no_walk, out_free;
    skht_pkg::cnt_t     cnt_new;

    // Request checks; act, pos and count hold still until the result is committed.
    always_comb begin
        pos_w    = skht_pkg::cmp_t'(pos_reg);
        cnt_w    = skht_pkg::cmp_t'(cnt_reg);
        full     = (cnt_reg == skht_pkg::cnt_t'(skht_pkg::CAPACITY));
        rem_tail = ((pos_w + skht_pkg::cmp_t'(1)) == cnt_w);
        pos_idx  = skht_pkg::idx_t'(pos_reg);
        err      = skht_pkg::RS_OK;
        unique case (act_reg)
            skht_pkg::ACT_ADD: begin
                if (full) err = skht_pkg::RS_FULL;
            end
            skht_pkg::ACT_INSERT: begin
                if (full) begin
                    err = skht_pkg::RS_FULL;
                end else if (pos_w > cnt_w) begin
                    err = skht_pkg::RS_BAD_POS;
                end
            end
            skht_pkg::ACT_REMOVE, skht_pkg::ACT_READ: begin
                if (pos_w >= cnt_w) err = skht_pkg::RS_BAD_POS;
            end
            default: begin
            end
        endcase
    end

    // Where the pass starts and whether one is needed at all.
    always_comb begin
        start_addr = '0;
        no_walk    = (err != skht_pkg::RS_OK);
        unique case (act_reg)
            skht_pkg::ACT_ADD: start_addr = '0;
            skht_pkg::ACT_INSERT, skht_pkg::ACT_READ: start_addr = pos_idx;
            skht_pkg::ACT_REMOVE: begin
                start_addr = pos_idx + skht_pkg::idx_t'(1);
                if (rem_tail) no_walk = 1'b1;
            end
            skht_pkg::ACT_FIND: begin
                start_addr = '0;
                if (cnt_reg == '0) no_walk = 1'b1;
            end
            default: no_walk = 1'b1;
        endcase
    end

    // One entry per cycle: rdata_reg holds the entry at proc_reg.
    always_comb begin
        new_entry  = '{key: key_reg, hnd: hnd_reg};
        at_end     = (skht_pkg::cnt_t'(proc_reg) == cnt_reg);
        at_last    = (skht_pkg::cnt_t'(proc_reg) == (cnt_reg - skht_pkg::cnt_t'(1)));
        step_we    = 1'b0;
        step_last  = 1'b0;
        waddr      = proc_reg;
        wdata      = carry_reg;
        shift_next = shift_reg;
        carry_next = carry_reg;
        ridx_next  = ridx_reg;
        found_next = found_reg;
        kout_next  = kout_reg;
        hout_next  = hout_reg;
        unique case (act_reg)
            skht_pkg::ACT_ADD, skht_pkg::ACT_INSERT: begin
                if (shift_reg) begin
                    // Ripple: store the carried entry, pick up the one displaced.
                    step_we    = 1'b1;
                    carry_next = rdata_reg;
                    step_last  = at_end;
                end else if (at_end ||
                             ($signed(rdata_reg.key) > $signed(key_reg))) begin
                    // First larger key, or the end: the new entry lands here.
                    step_we    = 1'b1;
                    wdata      = new_entry;
                    carry_next = rdata_reg;
                    shift_next = 1'b1;
                    ridx_next  = skht_pkg::ridx_t'(proc_reg);
                    step_last  = at_end;
                end
            end
            skht_pkg::ACT_REMOVE: begin
                step_we   = 1'b1;
                waddr     = proc_reg - skht_pkg::idx_t'(1);
                wdata     = rdata_reg;
                step_last = at_last;
            end
            skht_pkg::ACT_FIND: begin
                if (rdata_reg.key == key_reg) begin
                    found_next = 1'b1;
                    ridx_next  = skht_pkg::ridx_t'(proc_reg);
                    kout_next  = rdata_reg.key;
                    hout_next  = rdata_reg.hnd;
                    step_last  = 1'b1;
                end else begin
                    step_last = at_last;
                end
            end
            skht_pkg::ACT_READ: begin
                kout_next = rdata_reg.key;
                hout_next = rdata_reg.hnd;
                step_last = 1'b1;
            end
            default: begin
                step_last = 1'b1;
            end
        endcase
    end

    // Count after the request.
    always_comb begin
        cnt_new = cnt_reg;
        if (err == skht_pkg::RS_OK) begin
            unique case (act_reg)
                skht_pkg::ACT_ADD, skht_pkg::ACT_INSERT:
                    cnt_new = cnt_reg + skht_pkg::cnt_t'(1);
                skht_pkg::ACT_REMOVE:
                    cnt_new = cnt_reg - skht_pkg::cnt_t'(1);
                skht_pkg::ACT_CLEAR:
                    cnt_new = '0;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        rd_addr      = cmd.start ? start_addr : rd_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        proc_next    = proc_reg;
        if (cmd.start || cmd.step) begin
            rd_ptr_next = rd_addr + skht_pkg::idx_t'(1);
            proc_next   = rd_addr;
        end
        cnt_next     = cmd.finish ? cnt_new : cnt_reg;
        out_free     = !m_valid_reg || m_ready;
        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        act_next = skht_pkg::action_t'(s_action);
        key_next = s_key;
        hnd_next = skht_pkg::hnd_from_port(s_handle);
        pos_next = s_position;
    end

    assign stat = '{no_walk: no_walk, step_last: step_last, out_free: out_free};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg   <= act_next;
            key_reg   <= key_next;
            hnd_reg   <= hnd_next;
            pos_reg   <= pos_next;
            shift_reg <= (act_next == skht_pkg::ACT_INSERT);
            carry_reg <= '{key: key_next, hnd: hnd_next};
            if (act_next == skht_pkg::ACT_INSERT || act_next == skht_pkg::ACT_REMOVE ||
                act_next == skht_pkg::ACT_READ) begin
                ridx_reg <= skht_pkg::ridx_t'(pos_next);
            end else begin
                ridx_reg <= '0;
            end
            found_reg <= 1'b0;
            kout_reg  <= '0;
            hout_reg  <= '0;
        end else if (cmd.step) begin
            shift_reg <= shift_next;
            carry_reg <= carry_next;
            ridx_reg  <= ridx_next;
            found_reg <= found_next;
            kout_reg  <= kout_next;
            hout_reg  <= hout_next;
        end
        rd_ptr_reg <= rd_ptr_next;
        proc_reg   <= proc_next;
        if (cmd.finish) begin
            m_ridx_reg  <= (err == skht_pkg::RS_OK) ? ridx_reg : '0;
            m_found_reg <= found_reg;
            m_key_reg   <= kout_reg;
            m_hnd_reg   <= skht_pkg::hnd_to_port(hout_reg);
            m_cnt_reg   <= skht_pkg::ecnt_t'(cnt_new);
            m_stat_reg  <= err;
        end
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (step_we && cmd.step) begin
            entry_mem[waddr] <= wdata;
        end
        rdata_reg <= entry_mem[rd_addr];
    end

    assign m_valid        = m_valid_reg;
    assign m_result_index = m_ridx_reg;
    assign m_found        = m_found_reg;
    assign m_key_out      = m_key_reg;
    assign m_handle_out   = m_hnd_reg;
    assign m_entry_count  = m_cnt_reg;
    assign m_status       = m_stat_reg;

endmodule

`default_nettype wire

// File: rtl/core/sorted_key_handle_table.sv
// Top level of the sorted key/handle table: sequencer plus datapath.
// Depends on skht_pkg, skht_ctrl and skht_dpath.
//
//  Channel   Direction  Handshake          Fields
//  s_        in         s_valid/s_ready    action, key, handle, position
//  m_        out        m_valid/m_ready    result_index, found, key_out,
//                                          handle_out, entry_count, status
//
// One request is worked on at a time. It is captured, checked, passed over the
// table and committed, and the result shows on the m_ side in the cycle after
// the commit. The pass handles one entry per cycle through the single-port
// read of the entry memory: a sorted add walks count + 1 entries, an insert
// count - position + 1, a remove count - position - 1, a find up to count, a
// read one.
// Reset is synchronous and active low; it empties the table at once (only
// the entry count is cleared, memory contents are left as they are).
// A new request is taken while an earlier result still waits on the m_ side;
// the commit step holds until that result has been taken.
`default_nettype none

module sorted_key_handle_table (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_action,
    input  wire logic signed [31:0] s_key,
    input  wire logic [15:0]        s_handle,
    input  wire logic [5:0]         s_position,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [5:0]              m_result_index,
    output logic                    m_found,
    output logic signed [31:0]      m_key_out,
    output logic [15:0]             m_handle_out,
    output logic [6:0]              m_entry_count,
    output logic [1:0]              m_status
);

    // Commands go from the sequencer to the datapath, status comes back.
    skht_pkg::ctrl_cmd_t  cmd;
    skht_pkg::dp_status_t stat;

    // The sequencer owns s_ready and walks the request through its steps.
    skht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the table, the request and the result register.
    skht_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_action       (s_action),
        .s_key          (s_key),
        .s_handle       (s_handle),
        .s_position     (s_position),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_result_index (m_result_index),
        .m_found        (m_found),
        .m_key_out      (m_key_out),
        .m_handle_out   (m_handle_out),
        .m_entry_count  (m_entry_count),
        .m_status       (m_status)
    );

endmodule

`default_nettype wire

// File: rtl/core/skht_checker.sv
// Port-level checks for sorted_key_handle_table, attached with a bind.
// Depends on skht_pkg for the status codes and the table size.
`default_nettype none

module skht_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic [2:0]         s_action,
    input wire logic signed [31:0] s_key,
    input wire logic [15:0]        s_handle,
    input wire logic [5:0]         s_position,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [5:0]         m_result_index,
    input wire logic               m_found,
    input wire logic signed [31:0] m_key_out,
    input wire logic [15:0]        m_handle_out,
    input wire logic [6:0]         m_entry_count,
    input wire logic [1:0]         m_status
);

    // A stalled result keeps its count and index.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_entry_count) &&
                                 $stable(m_result_index))
        else $error("result changed while stalled");

    // Only one request is in work: taking one drops ready.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in work");

    // A refused request reports nothing but count and status.
    a_error_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != skht_pkg::RS_OK) |->
            (m_result_index == '0) && !m_found && (m_key_out == '0) &&
            (m_handle_out == '0))
        else $error("refused request carries data");

    // A full report means the table really is at capacity.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == skht_pkg::RS_FULL) |->
            (m_entry_count == skht_pkg::ecnt_t'(skht_pkg::CAPACITY)))
        else $error("full status with a table that is not full");

    // A found key lies inside the table.
    a_found_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |->
            (m_status == skht_pkg::RS_OK) && ({1'b0, m_result_index} < m_entry_count))
        else $error("found index outside the table");

endmodule

bind sorted_key_handle_table skht_checker u_checker (.*);

`default_nettype wire

// File: tb/skht_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the sorted key/handle table: it watches both channels, predicts every
// result from a private copy of the table, and compares the results field by field.
// Depends on skht_pkg for the table geometry, the field types and the action codes.

module skht_result_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [2:0]         s_action,
    input  wire logic signed [31:0] s_key,
    input  wire logic [15:0]        s_handle,
    input  wire logic [5:0]         s_position,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic [5:0]         m_result_index,
    input  wire logic               m_found,
    input  wire logic signed [31:0] m_key_out,
    input  wire logic [15:0]        m_handle_out,
    input  wire logic [6:0]         m_entry_count,
    input  wire logic [1:0]         m_status,
    output int                      mismatch_count,
    output int                      results_pending,
    output int                      results_checked
);
    import skht_pkg::*;

    typedef struct packed {
        ridx_t          index;
        logic           found;
        key_t           key;
        hout_t          hnd;
        ecnt_t          count;
        result_status_t status;
    } table_result_t;

    key_t          shadow_keys [CAPACITY];
    hnd_t          shadow_hnds [CAPACITY];
    int            shadow_fill;
    table_result_t expected_results [$];

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want_v, input int idx);
        if (got !== want_v) begin
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      idx, name, got, want_v));
        end
    endtask

    function automatic void open_gap(input int at);
        for (int i = shadow_fill; i > at; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_hnds[i] = shadow_hnds[i-1];
        end
        shadow_fill++;
    endfunction

    // Applies one request to the private table and returns the result it should give.
    function automatic table_result_t apply_table_request(input logic [2:0] act, input key_t key,
                                                          input hout_t hin, input pos_t pos);
        table_result_t r;
        int slot;
        r = '0;
        case (act)
            ACT_ADD: begin
                if (shadow_fill >= CAPACITY) begin
                    r.status = RS_FULL;
                end else begin
                    slot = 0;
                    while (slot < shadow_fill && !(key < shadow_keys[slot])) slot++;
                    open_gap(slot);
                    shadow_keys[slot] = key;
                    shadow_hnds[slot] = hnd_t'(hin);
                    r.index = ridx_t'(slot);
                end
            end
            ACT_INSERT: begin
                if (shadow_fill >= CAPACITY) begin
                    r.status = RS_FULL;
                end else if (int'(pos) > shadow_fill) begin
                    r.status = RS_BAD_POS;
                end else begin
                    open_gap(int'(pos));
                    shadow_keys[pos] = key;
                    shadow_hnds[pos] = hnd_t'(hin);
                    r.index = ridx_t'(pos);
                end
            end
            ACT_REMOVE: begin
                if (int'(pos) >= shadow_fill) begin
                    r.status = RS_BAD_POS;
                end else begin
                    for (int i = int'(pos); i + 1 < shadow_fill; i++) begin
                        shadow_keys[i] = shadow_keys[i+1];
                        shadow_hnds[i] = shadow_hnds[i+1];
                    end
                    shadow_fill--;
                    r.index = ridx_t'(pos);
                end
            end
            ACT_FIND: begin
                slot = 0;
                while (slot < shadow_fill && shadow_keys[slot] != key) slot++;
                if (slot < shadow_fill) begin
                    r.found = 1'b1;
                    r.index = ridx_t'(slot);
                    r.key   = shadow_keys[slot];
                    r.hnd   = hout_t'(shadow_hnds[slot]);
                end
            end
            ACT_READ: begin
                if (int'(pos) >= shadow_fill) begin
                    r.status = RS_BAD_POS;
                end else begin
                    r.index = ridx_t'(pos);
                    r.key   = shadow_keys[pos];
                    r.hnd   = hout_t'(shadow_hnds[pos]);
                end
            end
            ACT_CLEAR: shadow_fill = 0;
            default: ;
        endcase
        r.count = ecnt_t'(shadow_fill);
        return r;
    endfunction

    // Results are compared before the request of the same edge is predicted, so a result
    // can never be matched against the request that is only being accepted now.
    always @(posedge aclk) begin
        table_result_t want;
        if (!aresetn) begin
            shadow_fill = 0;
            expected_results.delete();
            mismatch_count  = 0;
            results_pending = 0;
            results_checked = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("result_index", 32'(m_result_index), 32'(want.index),
                                results_checked);
                    check_field("found", 32'(m_found), 32'(want.found), results_checked);
                    check_field("key_out", m_key_out, want.key, results_checked);
                    check_field("handle_out", 32'(m_handle_out), 32'(want.hnd), results_checked);
                    check_field("entry_count", 32'(m_entry_count), 32'(want.count),
                                results_checked);
                    check_field("status", 32'(m_status), 32'(want.status), results_checked);
                end
                results_checked++;
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(apply_table_request(s_action, s_key, s_handle,
                                                               s_position));
            end
            results_pending = expected_results.size();
        end
    end

endmodule

// File: tb/sorted_key_handle_table_test.sv
`timescale 1ns / 100ps
// Top of the sorted key/handle table testbench: clock, reset, request stimulus, result
// back-pressure, watchdog and verdict. Depends on skht_pkg, the block and skht_result_checker.

module sorted_key_handle_table_test;
    import skht_pkg::*;

    // The action field is three bits wide but only six codes are defined; the block must
    // treat the other two as no-ops that still answer.
    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;

    localparam int IDLE_PCT        = 31;
    localparam int RANDOM_REQUESTS = 1350;
    localparam int PHASE_LEN       = 120;
    localparam int CALM_FIRST      = 400;   // random requests without idling on either side
    localparam int CALM_LAST       = 700;
    localparam int HOLD_AT         = 900;   // request number that starts the long stall
    localparam int RX_HOLD_CYCLES  = 300;
    // Worst correct case: a full table pass per request plus the long receiver stall.
    localparam int WATCHDOG_LIMIT  = 8 * (CAPACITY + 3) + 4 * RX_HOLD_CYCLES;
    localparam int DRAIN_CYCLES    = 2 * (CAPACITY + 3);

    logic               aclk       = 1'b0;
    logic               aresetn    = 1'b0;
    logic               s_valid    = 1'b0;
    logic               s_ready;
    logic [2:0]         s_action   = '0;
    logic signed [31:0] s_key      = '0;
    logic [15:0]        s_handle   = '0;
    logic [5:0]         s_position = '0;
    logic               m_valid;
    logic               m_ready    = 1'b0;
    logic [5:0]         m_result_index;
    logic               m_found;
    logic signed [31:0] m_key_out;
    logic [15:0]        m_handle_out;
    logic [6:0]         m_entry_count;
    logic [1:0]         m_status;

    int mismatch_count;
    int results_pending;
    int results_checked;

    // Stimulus-side bookkeeping. The fill estimate only steers the choice of positions so that
    // most requests land inside the table; it plays no part in checking.
    int table_fill_est  = 0;
    int requests_sent   = 0;
    int full_attempts   = 0;
    int idle_pct        = IDLE_PCT;
    int quiet_cycles    = 0;
    int hold_left       = 0;
    bit hold_taken      = 1'b0;
    bit rx_hold_request = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    sorted_key_handle_table i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_key          (s_key),
        .s_handle       (s_handle),
        .s_position     (s_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_index (m_result_index),
        .m_found        (m_found),
        .m_key_out      (m_key_out),
        .m_handle_out   (m_handle_out),
        .m_entry_count  (m_entry_count),
        .m_status       (m_status)
    );

    skht_result_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_key           (s_key),
        .s_handle        (s_handle),
        .s_position      (s_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_index  (m_result_index),
        .m_found         (m_found),
        .m_key_out       (m_key_out),
        .m_handle_out    (m_handle_out),
        .m_entry_count   (m_entry_count),
        .m_status        (m_status),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending),
        .results_checked (results_checked)
    );

    // Result side. It drops ready at random, and once asked it holds off for a long stretch
    // so that a result backs up, the block takes one more request and then stalls its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (rx_hold_request && !hold_taken) begin
            m_ready    <= 1'b0;
            hold_left  <= RX_HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // The watchdog counts cycles in which neither channel moves a request or a result.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles at %0t ns", quiet_cycles, $time);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Offers one request after a random gap and waits until the block accepts it. Valid is
    // left high afterwards, so back-to-back requests need no second assignment in a step.
    task automatic issue_request(input logic [2:0] act, input logic [31:0] key,
                                 input logic [15:0] hnd, input logic [5:0] pos);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= act;
        s_key      <= key;
        s_handle   <= hnd;
        s_position <= pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
        case (act)
            ACT_ADD: begin
                if (table_fill_est < CAPACITY) table_fill_est++;
                else full_attempts++;
            end
            ACT_INSERT: begin
                if (table_fill_est >= CAPACITY) full_attempts++;
                else if (int'(pos) <= table_fill_est) table_fill_est++;
            end
            ACT_REMOVE: if (int'(pos) < table_fill_est) table_fill_est--;
            ACT_CLEAR: table_fill_est = 0;
            default: ;
        endcase
    endtask

    // The random part cycles through growing, mixed and shrinking phases so that the table
    // regularly runs full as well as empty. Thresholds are cumulative percentages.
    function automatic logic [2:0] pick_action(input int mode);
        int roll;
        int t_add, t_ins, t_rem, t_find, t_read, t_clr;
        roll = $urandom_range(99);
        case (mode)
            0: begin t_add = 40; t_ins = 65; t_rem = 71; t_find = 84; t_read = 97; t_clr = 98; end
            1: begin t_add = 25; t_ins = 40; t_rem = 60; t_find = 78; t_read = 96; t_clr = 98; end
            default: begin
                t_add = 8; t_ins = 15; t_rem = 65; t_find = 80; t_read = 95; t_clr = 98;
            end
        endcase
        if (roll < t_add)  return ACT_ADD;
        if (roll < t_ins)  return ACT_INSERT;
        if (roll < t_rem)  return ACT_REMOVE;
        if (roll < t_find) return ACT_FIND;
        if (roll < t_read) return ACT_READ;
        if (roll < t_clr)  return ACT_CLEAR;
        return $urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B;
    endfunction

    // Half the keys come from a small pool so that duplicates and find hits are common;
    // the rest are the signed extremes, zero, all ones or fully random patterns.
    function automatic logic [31:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50) return 32'(int'($urandom_range(15)) - 8);
        if (roll < 60) begin
            case ($urandom_range(3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    initial begin
        logic [2:0]  act;
        logic [31:0] key;
        logic [5:0]  pos;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests: empty-table errors, signed extremes, duplicate keys, insertion at
        // both ends, found and missed lookups, reads and removals at the edges, spare codes.
        issue_request(ACT_READ,    32'h0,         16'h0000, 6'd0);
        issue_request(ACT_REMOVE,  32'h0,         16'h0000, 6'd0);
        issue_request(ACT_FIND,    32'h0,         16'h0000, 6'd0);
        issue_request(ACT_INSERT,  32'h5,         16'h1111, 6'd1);
        issue_request(ACT_SPARE_A, 32'hFFFF_FFFF, 16'hFFFF, 6'd63);
        issue_request(ACT_ADD,     32'h0,         16'h0000, 6'd0);
        issue_request(ACT_ADD,     32'h7FFF_FFFF, 16'hFFFF, 6'd0);
        issue_request(ACT_ADD,     32'h8000_0000, 16'h0001, 6'd0);
        issue_request(ACT_ADD,     32'h0,         16'h1234, 6'd0);
        issue_request(ACT_INSERT,  32'hFFFF_FFFF, 16'hA5A5, 6'd0);
        issue_request(ACT_INSERT,  32'h2A,        16'h5A5A, 6'(table_fill_est));
        issue_request(ACT_FIND,    32'h0,         16'h0000, 6'd0);
        issue_request(ACT_FIND,    32'h3039,      16'h0000, 6'd0);
        issue_request(ACT_FIND,    32'h8000_0000, 16'h0000, 6'd0);
        issue_request(ACT_READ,    32'h0,         16'h0000, 6'd0);
        issue_request(ACT_READ,    32'h0,         16'h0000, 6'(table_fill_est - 1));
        issue_request(ACT_READ,    32'h0,         16'h0000, 6'd63);
        issue_request(ACT_REMOVE,  32'h0,         16'h0000, 6'd0);
        issue_request(ACT_REMOVE,  32'h0,         16'h0000, 6'(table_fill_est - 1));
        issue_request(ACT_REMOVE,  32'h0,         16'h0000, 6'd40);
        issue_request(ACT_SPARE_B, 32'h0,         16'h0000, 6'd0);
        issue_request(ACT_INSERT,  32'h1,         16'hAAAA, 6'd63);
        issue_request(ACT_CLEAR,   32'h0,         16'h0000, 6'd0);
        issue_request(ACT_READ,    32'h0,         16'h0000, 6'd0);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == CALM_FIRST) idle_pct <= 0;
            if (n == CALM_LAST)  idle_pct <= IDLE_PCT;
            if (n == HOLD_AT)    rx_hold_request <= 1'b1;
            act = pick_action((n / PHASE_LEN) % 3);
            key = pick_key();
            if (act == ACT_INSERT && $urandom_range(99) < 85) begin
                pos = 6'($urandom_range(table_fill_est > 63 ? 63 : table_fill_est));
            end else if ((act == ACT_REMOVE || act == ACT_READ) && table_fill_est > 0 &&
                         $urandom_range(99) < 85) begin
                pos = 6'($urandom_range(table_fill_est - 1));
            end else begin
                pos = 6'($urandom_range(63));
            end
            issue_request(act, key, 16'($urandom_range(65535)), pos);
        end
        s_valid <= 1'b0;

        // One edge lets the checker register the last request before its queue is polled.
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run summary: %0d requests sent, %0d results checked, %0d adds or inserts on a full table.",
                 requests_sent, results_checked, full_attempts);
        $display("Every action, the spare codes, bad positions, missed finds and a long result stall were exercised.");
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sorted_key_handle_table.f
rtl/core/skht_pkg.sv
rtl/core/skht_ctrl.sv
rtl/core/skht_dpath.sv
rtl/core/sorted_key_handle_table.sv
rtl/core/skht_checker.sv
tb/skht_result_checker.sv
tb/sorted_key_handle_table_test.sv
